// ===== design/tasim_pkg.sv =====
// ---------------------------------------------------------------------------
// tasim_pkg: shared definitions for the ternary and-inverter graph simulator
// Item codes, ternary value codes, rail word types and control structs.
// ---------------------------------------------------------------------------
`default_nettype none

package tasim_pkg;

  localparam int NODES    = 1024;
  localparam int PATTERNS = 64;
  localparam int ADDR_W   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int PAT_W    = $clog2(PATTERNS);
  localparam int NODE_W   = 10;
  localparam int CNT_W    = 16;

  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_AND    = 3'd1;
  localparam logic [2:0] OP_COPY   = 3'd2;
  localparam logic [2:0] OP_INPUT  = 3'd3;
  localparam logic [2:0] OP_CONST0 = 3'd4;
  localparam logic [2:0] OP_SCORE  = 3'd5;
  localparam logic [2:0] OP_PICK   = 3'd6;
  localparam logic [2:0] OP_READ   = 3'd7;

  localparam logic [1:0] VAL_ZERO = 2'd0;
  localparam logic [1:0] VAL_ONE  = 2'd1;
  localparam logic [1:0] VAL_X    = 2'd2;

  localparam logic KIND_PICK = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef logic [PATTERNS-1:0] word_t;

  typedef struct packed {
    word_t zero;
    word_t one;
  } rail_t;

  typedef struct packed {
    logic  score;
    word_t bin;
    logic  start;
  } cnt_ctl_t;

  typedef struct packed {
    logic             done;
    logic [PAT_W-1:0] best_idx;
    logic [CNT_W-1:0] best_cnt;
  } cnt_stat_t;

  function automatic logic in_range(input logic [NODE_W-1:0] n);
    logic [31:0] wide;
    wide = {{(32-NODE_W){1'b0}}, n};
    return wide < NODES;
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(input logic [NODE_W-1:0] n);
    logic [31:0] wide;
    wide = {{(32-NODE_W){1'b0}}, n};
    return wide[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/tasim_if.sv =====
// ---------------------------------------------------------------------------
// tasim_if: item channels of the ternary simulator
// Request channel carries node items, response channel carries results.
// ---------------------------------------------------------------------------
`default_nettype none

interface tasim_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [9:0]  node;
  logic [9:0]  fanin_a;
  logic        invert_a;
  logic [9:0]  fanin_b;
  logic        invert_b;
  logic [1:0]  init_value;
  logic [63:0] random_bits;

  modport source (output valid, op, node, fanin_a, invert_a, fanin_b, invert_b,
                  init_value, random_bits, input ready);
  modport sink (input valid, op, node, fanin_a, invert_a, fanin_b, invert_b,
                init_value, random_bits, output ready);
endinterface

interface tasim_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [5:0]  best_pattern;
  logic [15:0] unknown_count;
  logic [1:0]  start_value;

  modport source (output valid, result_kind, best_pattern, unknown_count,
                  start_value, input ready);
  modport sink (input valid, result_kind, best_pattern, unknown_count,
                start_value, output ready);
endinterface

`default_nettype wire

// ===== design/tasim_rail_mem.sv =====
// ---------------------------------------------------------------------------
// tasim_rail_mem: node rail storage
// One write port and one registered read port holding both rails per node.
// ---------------------------------------------------------------------------
`default_nettype none

module tasim_rail_mem
  import tasim_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire rail_t             wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output rail_t                  rdata
);

  rail_t mem [NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/tasim_counters.sv =====
// ---------------------------------------------------------------------------
// tasim_counters: per-pattern binary counters and best-pattern search
// Scores add in parallel; a pick shifts the bank past one comparator and clears it.
// ---------------------------------------------------------------------------
`default_nettype none

module tasim_counters
  import tasim_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cnt_ctl_t ctl,
  output cnt_stat_t     stat
);

  logic [CNT_W-1:0] cnt [PATTERNS];
  logic             busy;
  logic [PAT_W-1:0] step;
  logic             done;
  logic [PAT_W-1:0] best_idx;
  logic [CNT_W-1:0] best_cnt;

  // While busy, the head of the bank holds the pattern numbered by step, so the
  // walk sees the patterns in order and a strict compare keeps the first.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PATTERNS; k++) begin
        cnt[k] <= '0;
      end
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        for (int k = 0; k < PATTERNS - 1; k++) begin
          cnt[k] <= cnt[k+1];
        end
        cnt[PATTERNS-1] <= '0;
        step <= step + 1'b1;
        if (step == PAT_W'(PATTERNS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (ctl.score) begin
        for (int k = 0; k < PATTERNS; k++) begin
          if (ctl.bin[k] && (cnt[k] != {CNT_W{1'b1}})) begin
            cnt[k] <= cnt[k] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && ((step == '0) || (cnt[0] > best_cnt))) begin
      best_cnt <= cnt[0];
      best_idx <= step;
    end
  end

  assign stat.done     = done;
  assign stat.best_idx = best_idx;
  assign stat.best_cnt = best_cnt;

endmodule

`default_nettype wire

// ===== design/ternary_aig_node_simulator.sv =====
// ---------------------------------------------------------------------------
// ternary_aig_node_simulator: dual-rail ternary AIG simulator, 64 patterns
// A small sequencer drives the rail memory's write and read ports and a counter bank.
// ---------------------------------------------------------------------------
//
//   Channel   Dir   Handshake             Moves
//   req       in    req.valid/req.ready   one node, score, pick or read item
//   rsp       out   rsp.valid/rsp.ready   one pick or read result item
//   cfg       in    cfg_write             register_count
//
// Steps per item: init, primary input and const0 go straight to the write
// state; score fetches the node and counts it; read fetches the node, then
// emits its result; and and copy fetch the two fanins one after another
// through the single read port of the rail memory. A pick shifts the 64
// counters of the counter bank past one comparator.
// Reset is synchronous and active high; it clears the counters, the chosen
// pattern and the control state. Node rails are not cleared.
// The result sits in an output register; the sequencer stalls only when a
// new result is ready while the previous one has not been taken.
// ---------------------------------------------------------------------------
`default_nettype none

module ternary_aig_node_simulator
  import tasim_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  tasim_req_if.sink        req,
  tasim_rsp_if.source      rsp,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_COMB = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_PICK = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]        state;
  logic [2:0]        state_next;

  // Latched item fields.
  logic [2:0]        op_r;
  logic [NODE_W-1:0] node_r;
  logic [NODE_W-1:0] fa_r;
  logic              ia_r;
  logic [NODE_W-1:0] fb_r;
  logic              ib_r;
  logic [1:0]        init_r;
  word_t             rnd_r;

  logic [CNT_W-1:0]  register_count;
  logic [PAT_W-1:0]  chosen_pattern;
  logic [1:0]        sv_r;
  rail_t             a_r;
  logic              rd_ok;

  logic              accept;
  logic              emit;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [NODE_W-1:0] rd_node;
  rail_t             mem_wdata;
  rail_t             mem_rdata;
  rail_t             b_fetch;
  rail_t             v_fetch;
  cnt_ctl_t          cnt_ctl;
  cnt_stat_t         cnt_stat;

  // Out-of-range nodes read as both rails clear; an inverted fanin swaps.
  function automatic rail_t fetch(input rail_t d, input logic ok, input logic inv);
    rail_t r;
    r = ok ? d : '0;
    if (inv) begin
      r = '{zero: r.one, one: r.zero};
    end
    return r;
  endfunction

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign emit      = (state == S_EMIT) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      register_count <= '0;
    end else if (cfg_write) begin
      register_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= req.op;
      node_r <= req.node;
      fa_r   <= req.fanin_a;
      ia_r   <= req.invert_a;
      fb_r   <= req.fanin_b;
      ib_r   <= req.invert_b;
      init_r <= req.init_value;
      rnd_r  <= req.random_bits;
    end
  end

  // Sequencer. Node writers go straight to the write cycle, two-fanin and
  // copy items fetch both operands, score and read fetch the node itself.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.op == OP_PICK) begin
            state_next = S_PICK;
          end else if ((req.op == OP_INIT) || (req.op == OP_INPUT) ||
                       (req.op == OP_CONST0)) begin
            state_next = S_COMB;
          end else begin
            state_next = S_RDA;
          end
        end
      end
      S_RDA: begin
        if ((op_r == OP_SCORE) || (op_r == OP_READ)) begin
          state_next = S_EVAL;
        end else begin
          state_next = S_RDB;
        end
      end
      S_RDB:  state_next = S_COMB;
      S_COMB: state_next = S_IDLE;
      S_EVAL: state_next = (op_r == OP_READ) ? S_EMIT : S_IDLE;
      S_PICK: state_next = cnt_stat.done ? S_EMIT : S_PICK;
      S_EMIT: state_next = emit ? S_IDLE : S_EMIT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Memory read side: one address per cycle, the range flag follows the
  // read so it lines up with the registered data.
  always_comb begin
    if (state == S_RDB) begin
      rd_node = fb_r;
    end else if ((op_r == OP_SCORE) || (op_r == OP_READ)) begin
      rd_node = node_r;
    end else begin
      rd_node = fa_r;
    end
  end

  assign mem_re    = (state == S_RDA) || (state == S_RDB);
  assign mem_raddr = to_addr(rd_node);

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_ok <= in_range(rd_node);
    end
    if (state == S_RDB) begin
      a_r <= fetch(mem_rdata, rd_ok, ia_r);
    end
  end

  assign b_fetch = fetch(mem_rdata, rd_ok, ib_r);
  assign v_fetch = fetch(mem_rdata, rd_ok, 1'b0);

  // Write data for the node being evaluated.
  always_comb begin
    unique case (op_r)
      OP_INIT: begin
        if (init_r == VAL_ZERO) begin
          mem_wdata = '{zero: '1, one: '0};
        end else if (init_r == VAL_ONE) begin
          mem_wdata = '{zero: '0, one: '1};
        end else begin
          mem_wdata = '0;
        end
      end
      OP_AND:   mem_wdata = '{zero: a_r.zero | b_fetch.zero, one: a_r.one & b_fetch.one};
      OP_COPY:  mem_wdata = a_r;
      OP_INPUT: mem_wdata = '{zero: rnd_r, one: ~rnd_r};
      default:  mem_wdata = '{zero: '1, one: '0};
    endcase
  end

  assign mem_we = (state == S_COMB) && in_range(node_r);

  tasim_rail_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (to_addr(node_r)),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // A node is binary in a pattern when either rail is set there.
  assign cnt_ctl.score = (state == S_EVAL) && (op_r == OP_SCORE);
  assign cnt_ctl.bin   = v_fetch.zero | v_fetch.one;
  assign cnt_ctl.start = accept && (req.op == OP_PICK);

  tasim_counters u_cnt (
    .clk  (clk),
    .rst  (rst),
    .ctl  (cnt_ctl),
    .stat (cnt_stat)
  );

  // Ternary value of the read node in the chosen pattern; is-zero wins.
  always_ff @(posedge clk) begin
    if ((state == S_EVAL) && (op_r == OP_READ)) begin
      if (v_fetch.zero[chosen_pattern]) begin
        sv_r <= VAL_ZERO;
      end else if (v_fetch.one[chosen_pattern]) begin
        sv_r <= VAL_ONE;
      end else begin
        sv_r <= VAL_X;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chosen_pattern <= '0;
    end else if (emit && (op_r == OP_PICK)) begin
      chosen_pattern <= cnt_stat.best_idx;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (op_r == OP_PICK) begin
        rsp.result_kind  <= KIND_PICK;
        rsp.best_pattern <= cnt_stat.best_idx;
        rsp.start_value  <= VAL_ZERO;
        if (register_count > cnt_stat.best_cnt) begin
          rsp.unknown_count <= register_count - cnt_stat.best_cnt;
        end else begin
          rsp.unknown_count <= '0;
        end
      end else begin
        rsp.result_kind   <= KIND_READ;
        rsp.best_pattern  <= chosen_pattern;
        rsp.unknown_count <= '0;
        rsp.start_value   <= sv_r;
      end
    end
  end

endmodule

`default_nettype wire
